### rtl/lfcs_pkg.sv
// Package for the launcher fire control sequencer: register indexes, reset values,
// mode and state codes, default widths. No dependencies.
package lfcs_pkg;

  // Default widths of the hold/duty counters and of the trigger position arithmetic
  localparam int unsigned CounterWidthDef  = 16;
  localparam int unsigned PositionWidthDef = 32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 3'd0,
    CFG_STICK_THR  = 3'd1,
    CFG_BURST      = 3'd2,
    CFG_COOLING    = 3'd3,
    CFG_BULLET     = 3'd4,
    CFG_ARRIVE     = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [15:0] LongPressRst = 16'd500;
  localparam logic [9:0]  StickThrRst  = 10'd600;
  localparam logic [15:0] BurstRst     = 16'd3000;
  localparam logic [15:0] CoolingRst   = 16'd1000;
  localparam logic [19:0] BulletRst    = 20'd8192;
  localparam logic [15:0] ArriveRst    = 16'd256;

  // Control modes
  localparam logic [1:0] MODE_KEYMOUSE = 2'd0;
  localparam logic [1:0] MODE_REMOTE   = 2'd1;

  // Friction wheel codes, as presented on fric_state_o
  typedef enum logic [1:0] {
    FRIC_OFF      = 2'd0,
    FRIC_UNSTABLE = 2'd1,
    FRIC_NORMAL   = 2'd2
  } fric_e;

  // Shoot mode codes, as presented on fire_state_o
  typedef enum logic [1:0] {
    FIRE_STOP   = 2'd0,
    FIRE_READY  = 2'd1,
    FIRE_BULLET = 2'd2
  } fire_e;

endpackage

### rtl/launcher_fire_control_sequencer.sv
// Launcher fire control sequencer: click/long-press qualification, auto fire duty cycle,
// friction and shoot mode sequencing, trigger target stepping. Depends on lfcs_pkg.
//
// One item is one 1 ms control tick. The block takes an item in every clock cycle as long
// as results are taken: an item first lands in an input register, and when the result
// register is free the per-tick logic updates the sequencer state, which is itself the
// result register. The result of an item is offered from that state register, and a
// new item may follow every cycle as long as results are taken. A result that waits
// on out_ready_i holds the state; the input register still takes one more item, and
// then in_ready_o drops. Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take
// effect at the clock edge and must come while no item is in flight. The trigger target
// wraps modulo 2^POSITION_WIDTH and is shown in its low 32 bits; hold and duty counters
// saturate at 2^COUNTER_WIDTH - 1.
module launcher_fire_control_sequencer
  import lfcs_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH  = CounterWidthDef,
  parameter int unsigned POSITION_WIDTH = PositionWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // tick items
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          control_mode_i,
  input  logic                left_button_i,
  input  logic                right_button_i,
  input  logic signed [10:0]  stick_value_i,
  input  logic                target_seen_i,
  input  logic                kill_switch_i,
  input  logic                stop_request_i,
  input  logic signed [31:0]  trigger_position_i,
  // result items
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          fric_state_o,
  output logic [1:0]          fire_state_o,
  output logic signed [31:0]  trigger_target_o,
  output logic                auto_fire_o,
  output logic                left_click_o,
  output logic                right_long_o
);

  localparam int unsigned CW = COUNTER_WIDTH;
  localparam int unsigned PW = POSITION_WIDTH;
  // common width for comparing a counter against a 16-bit register
  localparam int unsigned XW = (CW > 16) ? CW : 16;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] long_press_q, burst_q, cooling_q, arrive_q;
  logic [9:0]  stick_thr_q;
  logic [19:0] bullet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressRst;
      stick_thr_q  <= StickThrRst;
      burst_q      <= BurstRst;
      cooling_q    <= CoolingRst;
      bullet_q     <= BulletRst;
      arrive_q     <= ArriveRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_PRESS: long_press_q <= cfg_data_i[15:0];
        CFG_STICK_THR:  stick_thr_q  <= cfg_data_i[9:0];
        CFG_BURST:      burst_q      <= cfg_data_i[15:0];
        CFG_COOLING:    cooling_q    <= cfg_data_i[15:0];
        CFG_BULLET:     bullet_q     <= cfg_data_i;
        CFG_ARRIVE:     arrive_q     <= cfg_data_i[15:0];
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic [1:0]         s1_mode_q;
  logic               s1_left_q, s1_right_q, s1_target_q, s1_kill_q, s1_stop_q;
  logic signed [10:0] s1_stick_q;
  logic signed [31:0] s1_pos_q;

  logic advance;     // move the staged item through the tick logic
  logic out_valid_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_mode_q   <= control_mode_i;
      s1_left_q   <= left_button_i;
      s1_right_q  <= right_button_i;
      s1_stick_q  <= stick_value_i;
      s1_target_q <= target_seen_i;
      s1_kill_q   <= kill_switch_i;
      s1_stop_q   <= stop_request_i;
      s1_pos_q    <= trigger_position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state; it doubles as the result register
  // ---------------------------------------------------------------------------
  logic               left_prev_q, left_prev_d;
  logic               right_prev_q, right_prev_d;
  logic signed [10:0] stick_prev_q, stick_prev_d;
  logic [CW-1:0]      left_hold_q, left_hold_d;
  logic [CW-1:0]      right_hold_q, right_hold_d;
  logic               left_long_q, left_long_d;
  logic               right_long_q, right_long_d;
  logic [1:0]         mode_prev_q, mode_prev_d;
  logic               cool_phase_q, cool_phase_d;
  logic [CW-1:0]      burst_cnt_q, burst_cnt_d;
  logic [CW-1:0]      cool_cnt_q, cool_cnt_d;
  logic               auto_fire_q, auto_fire_d;
  fric_e              fric_q, fric_d;
  fire_e              fire_q, fire_d;
  logic [PW-1:0]      target_q, target_d;
  logic               pending_q, pending_d;
  logic               click_q, click_d;

  // Saturating hold counter; returns {flag, count}
  function automatic logic [CW:0] hold_track(input logic pressed, input logic [CW-1:0] cnt,
                                             input logic flag, input logic [15:0] limit);
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] lim_x;
    logic [CW-1:0] cnt_n;
    logic          flag_n;
    cnt_x  = XW'(cnt);
    lim_x  = XW'(limit);
    cnt_n  = cnt;
    flag_n = flag;
    if (pressed) begin
      if (cnt_x < lim_x && !(&cnt)) begin
        cnt_n = cnt + 1'b1;
      end else if (cnt_x >= lim_x) begin
        flag_n = 1'b1;
      end
    end else begin
      cnt_n  = '0;
      flag_n = 1'b0;
    end
    return {flag_n, cnt_n};
  endfunction

  logic signed [11:0] stick_x, stick_prev_x, thr_x, neg_thr_x;
  logic [PW-1:0]      pos_x, diff, mag;
  logic               clear_evt;

  always_comb begin
    stick_x      = 12'(s1_stick_q);
    stick_prev_x = 12'(stick_prev_q);
    thr_x        = signed'({2'b00, stick_thr_q});
    neg_thr_x    = -thr_x;
    pos_x        = PW'(s1_pos_q);

    left_prev_d  = left_prev_q;
    right_prev_d = right_prev_q;
    stick_prev_d = stick_prev_q;
    left_hold_d  = left_hold_q;
    right_hold_d = right_hold_q;
    left_long_d  = left_long_q;
    right_long_d = right_long_q;
    cool_phase_d = cool_phase_q;
    burst_cnt_d  = burst_cnt_q;
    cool_cnt_d   = cool_cnt_q;
    auto_fire_d  = auto_fire_q;
    fric_d       = fric_q;
    fire_d       = fire_q;
    target_d     = target_q;
    pending_d    = pending_q;
    click_d      = click_q;
    mode_prev_d  = s1_mode_q;
    diff         = '0;
    mag          = '0;

    // Qualify clicks and long presses; other modes keep the flags
    if (s1_mode_q == MODE_KEYMOUSE) begin
      click_d      = !left_prev_q && s1_left_q;
      left_prev_d  = s1_left_q;
      right_prev_d = s1_right_q;
      {left_long_d, left_hold_d}   = hold_track(s1_left_q, left_hold_q, left_long_q,
                                                long_press_q);
      {right_long_d, right_hold_d} = hold_track(s1_right_q, right_hold_q, right_long_q,
                                                long_press_q);
    end else if (s1_mode_q == MODE_REMOTE) begin
      click_d      = (stick_prev_x < thr_x) && (stick_x >= thr_x);
      stick_prev_d = s1_stick_q;
      {left_long_d, left_hold_d}   = hold_track(stick_x >= thr_x, left_hold_q, left_long_q,
                                                long_press_q);
      {right_long_d, right_hold_d} = hold_track(stick_x <= neg_thr_x, right_hold_q,
                                                right_long_q, long_press_q);
    end

    // Burst/cool duty cycle for auto fire, key-mouse mode only
    if (s1_mode_q == MODE_KEYMOUSE) begin
      if (!cool_phase_q) begin
        if (s1_target_q) begin
          if (XW'(burst_cnt_q) >= XW'(burst_q)) begin
            cool_phase_d = 1'b1;
            burst_cnt_d  = '0;
          end else begin
            if (!(&burst_cnt_q)) burst_cnt_d = burst_cnt_q + 1'b1;
            auto_fire_d = 1'b1;
          end
        end
      end else begin
        auto_fire_d = 1'b0;
        if (XW'(cool_cnt_q) >= XW'(cooling_q)) begin
          cool_phase_d = 1'b0;
          cool_cnt_d   = '0;
        end else if (!(&cool_cnt_q)) begin
          cool_cnt_d = cool_cnt_q + 1'b1;
        end
      end
    end

    // Switch between key-mouse and remote, kill switch or stop: drop flags, stand down
    clear_evt = (mode_prev_q == MODE_KEYMOUSE && s1_mode_q == MODE_REMOTE) ||
                (mode_prev_q == MODE_REMOTE && s1_mode_q == MODE_KEYMOUSE) ||
                s1_kill_q || s1_stop_q;
    if (clear_evt) begin
      left_hold_d  = '0;
      right_hold_d = '0;
      left_long_d  = 1'b0;
      right_long_d = 1'b0;
      click_d      = 1'b0;
      fire_d       = FIRE_STOP;
      fric_d       = FRIC_OFF;
    end

    // Friction: off -> unstable -> normal, unstable passes on within the tick
    if ((click_d || auto_fire_d) && fric_d == FRIC_OFF) fric_d = FRIC_UNSTABLE;
    if (fric_d == FRIC_UNSTABLE) fric_d = FRIC_NORMAL;

    // Shoot mode
    case (fire_d)
      FIRE_STOP: begin
        if (fric_d == FRIC_NORMAL) fire_d = FIRE_READY;
      end
      FIRE_READY: begin
        if (click_d || right_long_d || auto_fire_d) fire_d = FIRE_BULLET;
        if (fric_d == FRIC_UNSTABLE) fire_d = FIRE_STOP;
      end
      FIRE_BULLET: begin
        if (fric_d == FRIC_UNSTABLE) fire_d = FIRE_STOP;
      end
      default: ;
    endcase

    // Bullet: advance the target once, back to ready on arrival unless the right long press holds
    if (fire_d == FIRE_BULLET) begin
      if (!pending_q) begin
        target_d  = target_q + PW'(bullet_q);
        pending_d = 1'b1;
      end
      diff = pos_x - target_d;
      mag  = diff[PW-1] ? (~diff + 1'b1) : diff;
      if (mag < PW'(arrive_q)) begin
        pending_d = 1'b0;
        if (!right_long_d) fire_d = FIRE_READY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_prev_q  <= 1'b0;
      right_prev_q <= 1'b0;
      stick_prev_q <= '0;
      left_hold_q  <= '0;
      right_hold_q <= '0;
      left_long_q  <= 1'b0;
      right_long_q <= 1'b0;
      mode_prev_q  <= MODE_KEYMOUSE;
      cool_phase_q <= 1'b0;
      burst_cnt_q  <= '0;
      cool_cnt_q   <= '0;
      auto_fire_q  <= 1'b0;
      fric_q       <= FRIC_OFF;
      fire_q       <= FIRE_STOP;
      target_q     <= '0;
      pending_q    <= 1'b0;
      click_q      <= 1'b0;
    end else if (advance) begin
      left_prev_q  <= left_prev_d;
      right_prev_q <= right_prev_d;
      stick_prev_q <= stick_prev_d;
      left_hold_q  <= left_hold_d;
      right_hold_q <= right_hold_d;
      left_long_q  <= left_long_d;
      right_long_q <= right_long_d;
      mode_prev_q  <= mode_prev_d;
      cool_phase_q <= cool_phase_d;
      burst_cnt_q  <= burst_cnt_d;
      cool_cnt_q   <= cool_cnt_d;
      auto_fire_q  <= auto_fire_d;
      fric_q       <= fric_d;
      fire_q       <= fire_d;
      target_q     <= target_d;
      pending_q    <= pending_d;
      click_q      <= click_d;
    end
  end

  // Results: the state as left by the last item
  assign out_valid_o      = out_valid_q;
  assign fric_state_o     = fric_q;
  assign fire_state_o     = fire_q;
  assign trigger_target_o = 32'(target_q);
  assign auto_fire_o      = auto_fire_q;
  assign left_click_o     = click_q;
  assign right_long_o     = right_long_q;

endmodule

### test/launcher_fire_control_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for launcher_fire_control_sequencer: a directed table, then random
// tick items across several register settings, checked against a local predictor.
// Depends on lfcs_pkg and the launcher_fire_control_sequencer RTL.
module launcher_fire_control_sequencer_test;
  import lfcs_pkg::*;

  // Hold and duty counters stop at this value
  localparam int unsigned CntTop = (1 << CounterWidthDef) - 1;
  // Control modes without a name in the package: both mean "no qualification"
  localparam logic [1:0] MODE_OTHER = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 135;
  // Idle margin after every owed status has come back
  localparam int DrainCycles = 4;
  localparam int RunLimit    = 250000;

  // One tick item, as it goes onto the input ports
  typedef struct packed {
    logic [1:0]         mode;
    logic               lbtn;
    logic               rbtn;
    logic signed [10:0] stick;
    logic               tgt;
    logic               kill;
    logic               stop;
    logic signed [31:0] pos;
  } tick_t;

  // One result item: the launcher status after a tick
  typedef struct packed {
    fric_e              fric;
    fire_e              fire;
    logic signed [31:0] aim;
    logic               autof;
    logic               click;
    logic               rlong;
  } status_t;

  typedef struct packed {
    tick_t   t;
    logic    typed;
    status_t want;
  } plan_row_t;

  localparam status_t NoStatus = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           control_mode_i = '0;
  logic                 left_button_i = 1'b0;
  logic                 right_button_i = 1'b0;
  logic signed [10:0]   stick_value_i = '0;
  logic                 target_seen_i = 1'b0;
  logic                 kill_switch_i = 1'b0;
  logic                 stop_request_i = 1'b0;
  logic signed [31:0]   trigger_position_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           fric_state_o;
  logic [1:0]           fire_state_o;
  logic signed [31:0]   trigger_target_o;
  logic                 auto_fire_o;
  logic                 left_click_o;
  logic                 right_long_o;

  launcher_fire_control_sequencer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .control_mode_i    (control_mode_i),
    .left_button_i     (left_button_i),
    .right_button_i    (right_button_i),
    .stick_value_i     (stick_value_i),
    .target_seen_i     (target_seen_i),
    .kill_switch_i     (kill_switch_i),
    .stop_request_i    (stop_request_i),
    .trigger_position_i(trigger_position_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .fric_state_o      (fric_state_o),
    .fire_state_o      (fire_state_o),
    .trigger_target_o  (trigger_target_o),
    .auto_fire_o       (auto_fire_o),
    .left_click_o      (left_click_o),
    .right_long_o      (right_long_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------
  // Predictor: register copies and sequencer state
  // ---------------------------------------------------------------------------------
  int unsigned lp_cfg, thr_cfg, burst_cfg, cool_cfg, step_cfg, tol_cfg;

  bit          seen_lbtn, seen_rbtn, l_long_q, r_long_q, click_q;
  int          stick_last;
  int unsigned l_hold, r_hold, burst_n, cool_n;
  logic [1:0]  mode_last;
  bit          cooling, autof_q, shot_open;
  fric_e       fric_q;
  fire_e       fire_q;
  logic [31:0] aim_q;

  // Status items still owed by the block, oldest first
  status_t     owed_status[$];
  int          fail_count = 0;
  int          cyc_count = 0;

  // Sender burst bookkeeping
  int          burst_left = 0;

  // Random item generator: sticky fields so that holds, runs and duty cycles happen
  logic [1:0]         gen_mode = MODE_KEYMOUSE;
  bit                 gen_l, gen_r, gen_tgt;
  logic signed [10:0] gen_stick = '0;

  // Directed table; the status is typed in only where it is obvious from the rules
  plan_row_t dir_plan [22] = '{
    // idle "other" mode right after reset: everything off
    '{'{MODE_OTHER, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b1,
      '{FRIC_OFF, FIRE_STOP, 32'sd0, 1'b0, 1'b0, 1'b0}},
    // a click on the same tick as the kill switch is dropped
    '{'{MODE_KEYMOUSE, 1'b1, 1'b0, 11'sd0, 1'b0, 1'b1, 1'b0, 32'sd0}, 1'b1,
      '{FRIC_OFF, FIRE_STOP, 32'sd0, 1'b0, 1'b0, 1'b0}},
    '{'{MODE_KEYMOUSE, 1'b1, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    // fresh rising edge: friction straight to normal, shoot mode to ready
    '{'{MODE_KEYMOUSE, 1'b1, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b1,
      '{FRIC_NORMAL, FIRE_READY, 32'sd0, 1'b0, 1'b1, 1'b0}},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd8192}, 1'b0, NoStatus},
    // shot fired and trigger already at the new target
    '{'{MODE_KEYMOUSE, 1'b1, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd8192}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    // shot left in flight, then arrival one count inside the window
    '{'{MODE_KEYMOUSE, 1'b1, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b0, 32'sd16639}, 1'b0, NoStatus},
    // key-mouse to remote switch clears the stick click
    '{'{MODE_REMOTE, 1'b0, 1'b0, 11'sd1023, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_REMOTE, 1'b0, 1'b0, 11'sh400, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_REMOTE, 1'b0, 1'b0, 11'sd599, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_REMOTE, 1'b0, 1'b0, 11'sd600, 1'b0, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    // other modes freeze qualification and the duty cycle
    '{'{MODE_OTHER, 1'b1, 1'b1, -11'sd600, 1'b1, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_SPARE, 1'b1, 1'b1, 11'sd1023, 1'b1, 1'b0, 1'b0, 32'h7FFF_FFFF}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b0, 1'b0, 1'b1, 32'sd0}, 1'b0, NoStatus},
    // target seen starts auto fire
    '{'{MODE_KEYMOUSE, 1'b0, 1'b0, 11'sd0, 1'b1, 1'b0, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b1, 11'sd0, 1'b1, 1'b0, 1'b0, 32'h8000_0000}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b0, 1'b1, 11'sd0, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF}, 1'b0, NoStatus},
    // kill while auto fire is held: auto fire survives the clear
    '{'{MODE_KEYMOUSE, 1'b0, 1'b1, 11'sd0, 1'b1, 1'b1, 1'b0, 32'sd0}, 1'b0, NoStatus},
    '{'{MODE_KEYMOUSE, 1'b1, 1'b1, -11'sd1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, NoStatus}
  };

  task automatic model_reset();
    lp_cfg    = LongPressRst;
    thr_cfg   = StickThrRst;
    burst_cfg = BurstRst;
    cool_cfg  = CoolingRst;
    step_cfg  = BulletRst;
    tol_cfg   = ArriveRst;
    seen_lbtn = 1'b0; seen_rbtn = 1'b0; l_long_q = 1'b0; r_long_q = 1'b0;
    click_q   = 1'b0; stick_last = 0; l_hold = 0; r_hold = 0;
    burst_n   = 0; cool_n = 0; mode_last = MODE_KEYMOUSE;
    cooling   = 1'b0; autof_q = 1'b0; shot_open = 1'b0;
    fric_q    = FRIC_OFF; fire_q = FIRE_STOP; aim_q = '0;
  endtask

  // Saturating hold counter; the flag rises once the count has reached the register
  function automatic void hold_step(input bit pressed, inout int unsigned cnt,
                                    inout bit flag);
    if (pressed) begin
      if (cnt < lp_cfg && cnt < CntTop) cnt++;
      else if (cnt >= lp_cfg) flag = 1'b1;
    end else begin
      cnt  = 0;
      flag = 1'b0;
    end
  endfunction

  // Advance the sequencer by one tick and return the status it shows
  function automatic status_t step_launcher(input tick_t t);
    int          stk;
    int          thr;
    bit          clr;
    logic [31:0] diff;
    logic [31:0] span;
    status_t     s;
    stk = int'(t.stick);
    thr = int'(thr_cfg);

    // Press qualification: buttons in key-mouse mode, stick in remote mode
    if (t.mode == MODE_KEYMOUSE) begin
      click_q   = !seen_lbtn && t.lbtn;
      seen_lbtn = t.lbtn;
      seen_rbtn = t.rbtn;
      hold_step(t.lbtn, l_hold, l_long_q);
      hold_step(t.rbtn, r_hold, r_long_q);
    end else if (t.mode == MODE_REMOTE) begin
      click_q    = (stick_last < thr) && (stk >= thr);
      stick_last = stk;
      hold_step(stk >= thr, l_hold, l_long_q);
      hold_step(stk <= -thr, r_hold, r_long_q);
    end

    // Burst/cool duty cycle, key-mouse only
    if (t.mode == MODE_KEYMOUSE) begin
      if (!cooling) begin
        if (t.tgt) begin
          if (burst_n >= burst_cfg) begin
            cooling = 1'b1;
            burst_n = 0;
          end else begin
            if (burst_n < CntTop) burst_n++;
            autof_q = 1'b1;
          end
        end
      end else begin
        autof_q = 1'b0;
        if (cool_n >= cool_cfg) begin
          cooling = 1'b0;
          cool_n  = 0;
        end else if (cool_n < CntTop) begin
          cool_n++;
        end
      end
    end

    // Clear on a key-mouse/remote switch, the kill switch or a stop request
    clr = (mode_last == MODE_KEYMOUSE && t.mode == MODE_REMOTE) ||
          (mode_last == MODE_REMOTE && t.mode == MODE_KEYMOUSE) || t.kill || t.stop;
    if (clr) begin
      l_hold   = 0;
      r_hold   = 0;
      l_long_q = 1'b0;
      r_long_q = 1'b0;
      click_q  = 1'b0;
      fire_q   = FIRE_STOP;
      fric_q   = FRIC_OFF;
    end
    mode_last = t.mode;

    if ((click_q || autof_q) && fric_q == FRIC_OFF) fric_q = FRIC_UNSTABLE;
    if (fric_q == FRIC_UNSTABLE) fric_q = FRIC_NORMAL;

    case (fire_q)
      FIRE_STOP: begin
        if (fric_q == FRIC_NORMAL) fire_q = FIRE_READY;
      end
      FIRE_READY: begin
        if (click_q || r_long_q || autof_q) fire_q = FIRE_BULLET;
        if (fric_q == FRIC_UNSTABLE) fire_q = FIRE_STOP;
      end
      FIRE_BULLET: begin
        if (fric_q == FRIC_UNSTABLE) fire_q = FIRE_STOP;
      end
      default: ;
    endcase

    // One target advance per shot; arrival is a wrapped distance strictly inside tolerance
    if (fire_q == FIRE_BULLET) begin
      if (!shot_open) begin
        aim_q     = aim_q + step_cfg[31:0];
        shot_open = 1'b1;
      end
      diff = t.pos - aim_q;
      span = diff[31] ? -diff : diff;
      if (span < tol_cfg) begin
        shot_open = 1'b0;
        if (!r_long_q) fire_q = FIRE_READY;
      end
    end

    s.fric  = fric_q;
    s.fire  = fire_q;
    s.aim   = aim_q;
    s.autof = autof_q;
    s.click = click_q;
    s.rlong = r_long_q;
    return s;
  endfunction

  // ---------------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------------

  // Offer one tick item, hold it until accepted, record what it should produce,
  // then idle between bursts
  task automatic drive_tick(input tick_t t, input logic typed, input status_t want);
    status_t s;
    int      gap;
    in_valid_i         <= 1'b1;
    control_mode_i     <= t.mode;
    left_button_i      <= t.lbtn;
    right_button_i     <= t.rbtn;
    stick_value_i      <= t.stick;
    target_seen_i      <= t.tgt;
    kill_switch_i      <= t.kill;
    stop_request_i     <= t.stop;
    trigger_position_i <= t.pos;
    do @(posedge clk_i); while (!in_ready_o);
    s = step_launcher(t);
    owed_status.push_back(typed ? want : s);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Now and then a long burst, otherwise a short one; most bursts end in a gap
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Drop valid and hold until every owed status has come back, then let the pipe empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (owed_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write per cycle; the caller lowers the write enable after the batch
  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input int unsigned lp, input int unsigned thr,
                              input int unsigned bst, input int unsigned cl,
                              input int unsigned stp, input int unsigned tol);
    cfg_write(CFG_LONG_PRESS, CfgDataW'(lp));
    cfg_write(CFG_STICK_THR, CfgDataW'(thr));
    cfg_write(CFG_BURST, CfgDataW'(bst));
    cfg_write(CFG_COOLING, CfgDataW'(cl));
    cfg_write(CFG_BULLET, CfgDataW'(stp));
    cfg_write(CFG_ARRIVE, CfgDataW'(tol));
    cfg_we_i  <= 1'b0;
    lp_cfg    = lp & 32'hFFFF;
    thr_cfg   = thr & 32'h3FF;
    burst_cfg = bst & 32'hFFFF;
    cool_cfg  = cl & 32'hFFFF;
    step_cfg  = stp & 32'hF_FFFF;
    tol_cfg   = tol & 32'hFFFF;
    @(posedge clk_i);
  endtask

  // Random ticks: mostly steady modes and held inputs with positions near the target,
  // plus mode flips, kills, stops and wild positions as noise
  task automatic run_random(input int count, input bit pause_midway);
    tick_t       t;
    int          s;
    int          off;
    logic [31:0] base;
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) settle_idle();
      if ($urandom_range(0, 99) < 3) begin
        s = $urandom_range(0, 19);
        if (s < 9) gen_mode = MODE_KEYMOUSE;
        else if (s < 17) gen_mode = MODE_REMOTE;
        else if (s < 19) gen_mode = MODE_OTHER;
        else gen_mode = MODE_SPARE;
      end
      if ($urandom_range(0, 3) == 0) gen_l = !gen_l;
      if ($urandom_range(0, 9) == 0) gen_r = !gen_r;
      if ($urandom_range(0, 5) == 0) gen_tgt = !gen_tgt;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: s = 0;
          1: s = int'(thr_cfg) + int'($urandom_range(0, 4)) - 2;
          2: s = -int'(thr_cfg) + int'($urandom_range(0, 4)) - 2;
          3: s = int'($urandom_range(0, 2047)) - 1024;
          4: s = ($urandom_range(0, 1) == 0) ? 1023 : -1024;
          default: s = int'($urandom_range(0, 40)) - 20;
        endcase
        if (s > 1023) s = 1023;
        if (s < -1024) s = -1024;
        gen_stick = s[10:0];
      end

      // Aim at where the target is or is about to be, around the tolerance edges
      base = shot_open ? aim_q : aim_q + step_cfg[31:0];
      off  = int'($urandom_range(0, 2 * tol_cfg + 2)) - int'(tol_cfg) - 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: t.pos = base + off;
        4:          t.pos = base;
        5:          t.pos = aim_q + off;
        6, 7:       t.pos = $urandom();
        8:          t.pos = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default:    t.pos = int'($urandom_range(0, 2000)) - 1000;
      endcase

      t.mode  = gen_mode;
      t.lbtn  = gen_l;
      t.rbtn  = gen_r;
      t.stick = gen_stick;
      t.tgt   = gen_tgt;
      t.kill  = ($urandom_range(0, 59) == 0);
      t.stop  = ($urandom_range(0, 59) == 0);
      drive_tick(t, 1'b0, NoStatus);
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Receiver side: stall pattern cycling through always-ready, periodic, random and
  // long-stall stretches
  // ---------------------------------------------------------------------------------
  logic [7:0] rx_beat = '0;

  always @(posedge clk_i) begin
    rx_beat <= rx_beat + 8'd1;
    case (rx_beat[7:6])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= (rx_beat[1:0] != 2'd3);
      2'd2:    out_ready_i <= ($urandom_range(0, 9) < 6);
      default: out_ready_i <= (rx_beat[5:3] != 3'd5);
    endcase
  end

  // Compare each accepted status item with the oldest one owed
  always @(posedge clk_i) begin
    status_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_status.size() == 0) begin
        $error("status item with none owed: fric %0d fire %0d target %0d",
               fric_state_o, fire_state_o, trigger_target_o);
        fail_count++;
      end else begin
        due = owed_status.pop_front();
        if (fric_state_o !== due.fric) begin
          $error("fric_state: expected %0d, got %0d", due.fric, fric_state_o);
          fail_count++;
        end
        if (fire_state_o !== due.fire) begin
          $error("fire_state: expected %0d, got %0d", due.fire, fire_state_o);
          fail_count++;
        end
        if (trigger_target_o !== due.aim) begin
          $error("trigger_target: expected %0d, got %0d", due.aim, trigger_target_o);
          fail_count++;
        end
        if (auto_fire_o !== due.autof) begin
          $error("auto_fire: expected %0d, got %0d", due.autof, auto_fire_o);
          fail_count++;
        end
        if (left_click_o !== due.click) begin
          $error("left_click: expected %0d, got %0d", due.click, left_click_o);
          fail_count++;
        end
        if (right_long_o !== due.rlong) begin
          $error("right_long: expected %0d, got %0d", due.rlong, right_long_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: far above the slowest legal run
  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count > RunLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------
  initial begin
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset register values
    foreach (dir_plan[i]) drive_tick(dir_plan[i].t, dir_plan[i].typed, dir_plan[i].want);
    settle_idle();

    // Phase 0 puts every register at its low end, phase 1 at its high end; the rest
    // use small counts so that long presses and the burst/cool cycle turn over
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        program_regs(0, 0, 0, 0, 0, 0);
      end else if (ph == 1) begin
        program_regs(16'hFFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, 20'hF_FFFF, 16'hFFFF);
      end else begin
        program_regs($urandom_range(0, 12), $urandom_range(0, 1023),
                     $urandom_range(0, 20), $urandom_range(0, 10),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4000)
                                                 : $urandom_range(0, 20'hF_FFFF),
                     ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000)
                                                 : $urandom_range(0, 16'hFFFF));
      end
      // Phase 3 also holds the sender until every owed status is back
      run_random(PhaseItems, ph == 3);
      settle_idle();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
